### sv/mfhf_pkg.sv
// Package for the mesh frame header filter: header layout constants,
// result kind codes and the item/result structs. No dependencies.
`timescale 1ns / 1ps

package mfhf_pkg;

    localparam int unsigned RADIO_ADDR_BITS_DEF = 8;
    localparam int unsigned ID_W                = 32;
    localparam int unsigned POS_W               = 4;

    localparam logic [31:0] INIT_NODE_ID    = 32'h0000_0000;
    localparam logic [31:0] INIT_GATEWAY_ID = 32'h0000_0001;

    // header byte positions
    localparam logic [3:0] POS_DEST0 = 4'd0;
    localparam logic [3:0] POS_SRC0  = 4'd4;
    localparam logic [3:0] POS_TYPE  = 4'd8;
    localparam logic [3:0] POS_SUB   = 4'd9;
    localparam logic [3:0] HDR_LEN   = 4'd10;

    localparam logic [7:0] TYPE_ID   = 8'h01;
    localparam logic [7:0] SUB_OFFER = 8'h02;
    localparam logic [7:0] TYPE_FWD  = 8'h03;
    localparam logic [7:0] SUB_FWD   = 8'h00;

    // configuration register indexes
    localparam logic CFG_NODE_ID    = 1'b0;
    localparam logic CFG_GATEWAY_ID = 1'b1;

    typedef enum logic [2:0] {
        K_PAYLOAD  = 3'd0,
        K_EMPTY    = 3'd1,
        K_SHORT    = 3'd2,
        K_ASSIGNED = 3'd3,
        K_SAME     = 3'd4,
        K_IGNORED  = 3'd5
    } t_kind;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [7:0]       payload_byte;
        logic [ID_W-1:0]  sender_id;
        logic             message_last;
        logic [ID_W-1:0]  node_id_now;
        logic [ID_W-1:0]  gateway_id_now;
    } t_result;

endpackage

### sv/mfhf_ifs.sv
// Valid/ready channel interfaces for the frame byte input and the result output.
// Depends on mfhf_pkg.
`timescale 1ns / 1ps

interface mfhf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface mfhf_result_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                kind;
    logic [7:0]                payload_byte;
    logic [mfhf_pkg::ID_W-1:0] sender_id;
    logic                      message_last;
    logic [mfhf_pkg::ID_W-1:0] node_id_now;
    logic [mfhf_pkg::ID_W-1:0] gateway_id_now;

    modport source (output valid, output kind, output payload_byte, output sender_id,
                    output message_last, output node_id_now, output gateway_id_now,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input sender_id,
                    input message_last, input node_id_now, input gateway_id_now,
                    output ready);
endinterface

### sv/mfhf_core.sv
// Header capture, frame classification and node/gateway ID state.
// Depends on mfhf_pkg.
`timescale 1ns / 1ps

module mfhf_core #(
    parameter int unsigned RADIO_ADDR_BITS = mfhf_pkg::RADIO_ADDR_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  mfhf_pkg::t_in_item        i_item,
    input  logic                      i_cfg_wr_en,
    input  logic                      i_cfg_index,
    input  logic [mfhf_pkg::ID_W-1:0] i_cfg_wdata,
    output mfhf_pkg::t_result         o_result
);

    localparam logic [mfhf_pkg::ID_W-1:0] LOW_MASK =
        {{(mfhf_pkg::ID_W - RADIO_ADDR_BITS){1'b0}}, {RADIO_ADDR_BITS{1'b1}}};

    logic [mfhf_pkg::ID_W-1:0]  r_node_id, n_node_id;
    logic [mfhf_pkg::ID_W-1:0]  r_gateway_id, n_gateway_id;
    logic [mfhf_pkg::POS_W-1:0] r_pos, n_pos;
    logic [31:0]                r_dest, n_dest;
    logic [31:0]                r_src, n_src;
    logic [7:0]                 r_type, n_type;
    logic [7:0]                 r_sub, n_sub;

    logic in_hdr;
    logic is_offer;
    logic is_fwd_here;
    logic [7:0] b;

    assign b      = i_item.frame_byte;
    assign in_hdr = (r_pos < mfhf_pkg::HDR_LEN);

    // header fields as they stand after this byte
    always_comb begin
        n_dest = r_dest;
        n_src  = r_src;
        n_type = r_type;
        n_sub  = r_sub;
        if (in_hdr) begin
            if (r_pos < mfhf_pkg::POS_SRC0) begin
                n_dest = (r_pos == mfhf_pkg::POS_DEST0) ? {24'd0, b} : {r_dest[23:0], b};
            end else if (r_pos < mfhf_pkg::POS_TYPE) begin
                n_src = (r_pos == mfhf_pkg::POS_SRC0) ? {24'd0, b} : {r_src[23:0], b};
            end else if (r_pos == mfhf_pkg::POS_TYPE) begin
                n_type = b;
            end else begin
                n_sub = b;
            end
        end
    end

    assign is_offer    = (n_type == mfhf_pkg::TYPE_ID) && (n_sub == mfhf_pkg::SUB_OFFER)
                         && (n_src == 32'd0);
    assign is_fwd_here = !is_offer && (n_dest == r_node_id)
                         && (n_type == mfhf_pkg::TYPE_FWD) && (n_sub == mfhf_pkg::SUB_FWD);

    always_comb begin
        n_node_id    = r_node_id;
        n_gateway_id = r_gateway_id;
        n_pos        = r_pos;

        o_result              = '0;
        o_result.kind         = mfhf_pkg::K_IGNORED;

        if (i_step) begin
            if (in_hdr) begin
                n_pos = r_pos + 4'd1;
            end
            if (i_item.frame_end) begin
                n_pos = '0;
            end

            if (!in_hdr && is_fwd_here) begin
                o_result.valid        = 1'b1;
                o_result.kind         = mfhf_pkg::K_PAYLOAD;
                o_result.payload_byte = b;
                o_result.sender_id    = n_src;
                o_result.message_last = i_item.frame_end;
            end else if (i_item.frame_end) begin
                o_result.valid = 1'b1;
                if (in_hdr && (r_pos < mfhf_pkg::POS_SUB)) begin
                    o_result.kind = mfhf_pkg::K_SHORT;
                end else if (is_offer) begin
                    if (n_dest != r_node_id) begin
                        n_node_id     = n_dest;
                        n_gateway_id  = (n_dest & ~LOW_MASK) | (r_gateway_id & LOW_MASK);
                        o_result.kind = mfhf_pkg::K_ASSIGNED;
                    end else begin
                        o_result.kind = mfhf_pkg::K_SAME;
                    end
                end else if (is_fwd_here) begin
                    // forward with header only
                    o_result.kind         = mfhf_pkg::K_EMPTY;
                    o_result.sender_id    = n_src;
                    o_result.message_last = 1'b1;
                end else begin
                    o_result.kind = mfhf_pkg::K_IGNORED;
                end
            end
        end

        o_result.node_id_now    = n_node_id;
        o_result.gateway_id_now = n_gateway_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id    <= mfhf_pkg::INIT_NODE_ID;
            r_gateway_id <= mfhf_pkg::INIT_GATEWAY_ID;
            r_pos        <= '0;
            r_dest       <= '0;
            r_src        <= '0;
            r_type       <= '0;
            r_sub        <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == mfhf_pkg::CFG_NODE_ID) begin
                r_node_id <= i_cfg_wdata;
            end else begin
                r_gateway_id <= i_cfg_wdata;
            end
        end else if (i_step) begin
            r_node_id    <= n_node_id;
            r_gateway_id <= n_gateway_id;
            r_pos        <= n_pos;
            r_dest       <= n_dest;
            r_src        <= n_src;
            r_type       <= n_type;
            r_sub        <= n_sub;
        end
    end

endmodule

### sv/mesh_frame_header_filter.sv
// Top level of the mesh frame header filter: input register, core, result register.
// Depends on mfhf_pkg, mfhf_ifs (channel interfaces) and mfhf_core.
`timescale 1ns / 1ps

// Receive-side header filter. Frame bytes enter one per transaction on i_frame,
// the last byte of a frame flagged by frame_end. The first ten bytes are the header
// (dest ID and source ID, both big-endian, then type and subtype). Short frames are
// reported as dropped at their end. An ID offer (type 1/subtype 2, source 0)
// reassigns the node ID and re-prefixes the gateway ID at frame end; a forward
// (3/0) to this node yields one result per payload byte tagged with the source ID;
// or an empty one if it has none; anything else is reported as ignored at its end.
// Header bytes give no result unless they end the frame. Each byte passes one input
// register, then one result register. Throughput: one byte per clock unless a
// result waits for o_result.ready, during which the core holds its byte, whether
// or not that byte makes a result; the input register takes at most one more byte
// and then i_frame.ready drops. Config writes (index 0 node ID, index 1 gateway ID)
// take effect the next clock and must only be issued while the block is idle.

module mesh_frame_header_filter #(
    parameter int unsigned RADIO_ADDR_BITS = mfhf_pkg::RADIO_ADDR_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic                      i_cfg_index,
    input  logic [mfhf_pkg::ID_W-1:0] i_cfg_wdata,
    mfhf_frame_if.sink                i_frame,
    mfhf_result_if.source             o_result
);

    // input stage
    logic               r_in_vld, n_in_vld;
    mfhf_pkg::t_in_item r_in_item;

    // result stage
    logic               r_out_vld, n_out_vld;
    mfhf_pkg::t_result  r_out;
    mfhf_pkg::t_result  core_res;

    logic adv;   // input stage hands its byte to the core this cycle

    assign adv           = r_in_vld && (!r_out_vld || o_result.ready);
    assign i_frame.ready = !r_in_vld || adv;

    assign n_in_vld  = (i_frame.valid && i_frame.ready) || (r_in_vld && !adv);
    // a held result only clears when taken; adv implies the register is free or being taken
    assign n_out_vld = (adv && core_res.valid) || (r_out_vld && !o_result.ready);

    mfhf_core #(
        .RADIO_ADDR_BITS (RADIO_ADDR_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (adv),
        .i_item      (r_in_item),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (core_res)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_frame.valid && i_frame.ready) begin
            r_in_item.frame_byte <= i_frame.frame_byte;
            r_in_item.frame_end  <= i_frame.frame_end;
        end
        if (adv && core_res.valid) begin
            r_out <= core_res;
        end
    end

    assign o_result.valid          = r_out_vld;
    assign o_result.kind           = r_out.kind;
    assign o_result.payload_byte   = r_out.payload_byte;
    assign o_result.sender_id      = r_out.sender_id;
    assign o_result.message_last   = r_out.message_last;
    assign o_result.node_id_now    = r_out.node_id_now;
    assign o_result.gateway_id_now = r_out.gateway_id_now;

endmodule
